>>> rtl/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants of the button matrix scanner.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int ROW_W   = 3;
    localparam int COLS_W  = 8;
    localparam int IDX_W   = 6;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

    // one accepted scan, handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  next_row;
        logic [COLS_W-1:0] cols;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             pressed;
        logic             was_pressed;
        logic             changed;
        logic [ROW_W-1:0] drive_row;
        logic             last_event;
    } t_event;

endpackage

>>> rtl/bms_front.sv
// ----------------------------------------------------------------------------
// bms_front
// Scan throttle: accepts scan items, drops early ones, advances the row.
// ----------------------------------------------------------------------------
module bms_front
    import bms_pkg::*;
#(
    parameter int ROWS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [DELAY_W-1:0] i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [COLS_W-1:0]  i_column_bits,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [DELAY_W-1:0] r_delay;
    logic [ROW_W-1:0]   r_row;
    logic [TIME_W-1:0]  r_last_time;
    logic [ROW_W-1:0]   n_row;
    logic [TIME_W-1:0]  elapsed;
    logic               accept;
    logic               pass;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    // unsigned wrap of the timestamp difference
    assign elapsed = i_now_ms - r_last_time;
    assign pass    = elapsed >= TIME_W'(r_delay);
    assign o_push  = accept && pass;

    always_comb begin
        if ({1'b0, r_row} + 4'd1 >= 4'(ROWS)) begin
            n_row = '0;
        end else begin
            n_row = r_row + 3'd1;
        end
    end

    assign o_job.row      = r_row;
    assign o_job.next_row = n_row;
    assign o_job.cols     = i_column_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= DELAY_RESET;
            r_row       <= '0;
            r_last_time <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delay <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_row       <= n_row;
                r_last_time <= i_now_ms;
            end
        end
    end

endmodule

>>> rtl/bms_queue.sv
// ----------------------------------------------------------------------------
// bms_queue
// Two-entry job queue between throttle and event generator.
// ----------------------------------------------------------------------------
module bms_queue
    import bms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_empty = r_count == 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> rtl/bms_back.sv
// ----------------------------------------------------------------------------
// bms_back
// Event generator: one event per column, keeps per-row button states.
// ----------------------------------------------------------------------------
module bms_back
    import bms_pkg::*;
#(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  logic   i_q_empty,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_event o_event
);

    localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [COLUMNS-1:0] r_btn [ROWS];
    logic [COLUMNS-1:0] r_word;
    logic [COLUMNS-1:0] r_prev;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_next_row;
    logic [CIW-1:0]     r_col;
    logic               r_busy;
    logic               r_valid;
    t_event             r_event;

    logic               advance;
    logic               emit;
    logic               col_last;
    logic               load;
    logic [COLUMNS-1:0] job_word;
    logic [RIW-1:0]     job_ridx;

    // word bit c is column c, taken from column_bits bit 7-c
    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            job_word[c] = i_job.cols[COLS_W-1-c];
        end
    end

    assign job_ridx = i_job.row[RIW-1:0];
    assign advance  = !r_valid || i_ready;
    assign emit     = advance && r_busy;
    assign col_last = r_col == CIW'(COLUMNS - 1);
    assign load     = !i_q_empty && (!r_busy || (emit && col_last));
    assign o_pop    = load;
    assign o_valid  = r_valid;
    assign o_event  = r_event;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_event.button_index <= IDX_W'({3'b000, r_row} * IDX_W'(COLUMNS))
                                    + IDX_W'(r_col);
            r_event.pressed      <= r_word[r_col];
            r_event.was_pressed  <= r_prev[r_col];
            r_event.changed      <= r_word[r_col] ^ r_prev[r_col];
            r_event.drive_row    <= r_next_row;
            r_event.last_event   <= col_last;
        end
        if (load) begin
            r_word     <= job_word;
            r_prev     <= r_btn[job_ridx];
            r_row      <= i_job.row;
            r_next_row <= i_job.next_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_col   <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_btn[r] <= '0;
            end
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                // stored state updated at once; old word kept in r_prev
                r_btn[job_ridx] <= job_word;
                r_busy          <= 1'b1;
                r_col           <= '0;
            end else if (emit) begin
                if (col_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_col <= r_col + CIW'(1);
                end
            end
        end
    end

endmodule

>>> rtl/button_matrix_scanner_core.sv
// Path: an accepted scan passes the job queue and the event generator's job
//   registers before its first event is in the output register.
// Throughput: the event generator emits one column per cycle unless the output
//   stalls, and loads the next queued scan as it emits the last column.
// Reset: synchronous active low; clears row, last scan time, button states,
//   queue and output valid; scan delay returns to 10 ms.
// ----------------------------------------------------------------------------
// button_matrix_scanner_core
// Keypad matrix row scanner with scan throttle and per-button change events.
// ----------------------------------------------------------------------------
module button_matrix_scanner_core
    import bms_pkg::*;
#(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [DELAY_W-1:0] i_cfg_wr_data,   // scan_delay_ms
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,    // [31:0] now_ms, [39:32] column_bits
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [5:0] button_index, [6] pressed, [7] was_pressed, [8] changed,
    // [11:9] drive_row, [15:12] zero
    output logic [15:0]        m_axis_tdata,
    output logic               m_axis_tlast     // last_event
);

    t_job   push_job;
    t_job   pop_job;
    t_event evt;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;

    bms_front #(.ROWS(ROWS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_now_ms      (s_axis_tdata[31:0]),
        .i_column_bits (s_axis_tdata[39:32]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    bms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bms_back #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (pop_job),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_event   (evt)
    );

    assign m_axis_tdata = {4'b0000, evt.drive_row, evt.changed, evt.was_pressed,
                           evt.pressed, evt.button_index};
    assign m_axis_tlast = evt.last_event;

endmodule

>>> rtl/bms_checker.sv
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks of the button matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
module bms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled event holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled event changed");

    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8] == (m_axis_tdata[6] ^ m_axis_tdata[7]))
        else $error("changed flag inconsistent");

    // within a scan the next column follows in the next cycle
    a_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid
            && m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1
            && m_axis_tdata[11:9] == $past(m_axis_tdata[11:9]))
        else $error("column sequence broken");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("event valid after reset");

endmodule

bind button_matrix_scanner_core bms_checker u_bms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> dv/button_matrix_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// button_matrix_scanner_core testbench
// Sends scan attempts with timestamps and column levels, tracks the throttle,
// driven row and per-button states on the testbench side, and checks every
// column event field by field under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bms_pkg::*;

    localparam int ROWS          = 8;
    localparam int COLUMNS       = 8;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 5000;

    class keypad_scoreboard;
        logic [63:0]        key_down;
        logic [ROW_W-1:0]   row;
        logic [TIME_W-1:0]  last_scan_ms;
        logic [DELAY_W-1:0] delay_ms;
        t_event             events_due[$];
        int                 errors;

        function new();
            key_down     = '0;
            row          = '0;
            last_scan_ms = '0;
            delay_ms     = DELAY_RESET;
            errors       = 0;
        endfunction

        function void set_delay(input logic [DELAY_W-1:0] d);
            delay_ms = d;
        endfunction

        // returns 1 when the scan gets past the throttle
        function bit note_scan(input logic [TIME_W-1:0] now_ms,
                               input logic [COLS_W-1:0] cols);
            logic [TIME_W-1:0] elapsed;
            logic [ROW_W-1:0]  next_row;
            t_event            ev;
            elapsed = now_ms - last_scan_ms;   // wraps modulo 2^32
            if (elapsed < delay_ms)
                return 1'b0;
            next_row = (int'(row) >= ROWS - 1) ? '0 : row + 1'b1;
            for (int c = 0; c < COLUMNS; c++) begin
                ev.button_index = IDX_W'(int'(row) * COLUMNS + c);
                ev.pressed      = cols[7 - c];   // column 0 sits in bit 7
                ev.was_pressed  = key_down[ev.button_index];
                ev.changed      = ev.pressed ^ ev.was_pressed;
                ev.drive_row    = next_row;
                ev.last_event   = (c == COLUMNS - 1);
                key_down[ev.button_index] = ev.pressed;
                events_due.push_back(ev);
            end
            row          = next_row;
            last_scan_ms = now_ms;
            return 1'b1;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_event(input logic [15:0] data, input logic last);
            t_event ev;
            if (events_due.size() == 0) begin
                report($sformatf("event with none pending: data=%h last=%b", data, last));
                return;
            end
            ev = events_due.pop_front();
            if (data[5:0] !== ev.button_index)
                report($sformatf("button_index %0d, want %0d", data[5:0], ev.button_index));
            if (data[6] !== ev.pressed)
                report($sformatf("button %0d pressed %b, want %b",
                                 ev.button_index, data[6], ev.pressed));
            if (data[7] !== ev.was_pressed)
                report($sformatf("button %0d was_pressed %b, want %b",
                                 ev.button_index, data[7], ev.was_pressed));
            if (data[8] !== ev.changed)
                report($sformatf("button %0d changed %b, want %b",
                                 ev.button_index, data[8], ev.changed));
            if (data[11:9] !== ev.drive_row)
                report($sformatf("button %0d drive_row %0d, want %0d",
                                 ev.button_index, data[11:9], ev.drive_row));
            if (last !== ev.last_event)
                report($sformatf("button %0d last %b, want %b",
                                 ev.button_index, last, ev.last_event));
            if (data[15:12] !== 4'd0)
                report($sformatf("button %0d pad bits %h", ev.button_index, data[15:12]));
        endtask

        function int pending();
            return events_due.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [DELAY_W-1:0] i_cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata;    // [31:0] now_ms, [39:32] column_bits
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [5:0] button_index, [6] pressed, [7] was_pressed, [8] changed,
    // [11:9] drive_row, [15:12] zero
    logic [15:0]        m_axis_tdata;
    logic               m_axis_tlast;    // last_event

    keypad_scoreboard   sb;
    int                 idle_pct;
    int                 stall_pct;
    int                 quiet_cycles = 0;
    logic [TIME_W-1:0]  clock_ms;
    bit                 scan_taken;

    button_matrix_scanner_core #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("button_matrix_scanner_core test failed");
            $finish;
        end
    end

    // starts and ends on a falling edge; tvalid stays high for a following item
    task automatic send_scan(input logic [TIME_W-1:0] now_ms,
                             input logic [COLS_W-1:0] cols, output bit taken);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cols, now_ms};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        taken    = sb.note_scan(now_ms, cols);
        clock_ms = now_ms;
        @(negedge i_clk);
    endtask

    // hold off until every pending event is out, plus slack for a dropped scan
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] d);
        wait_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_delay(d);
    endtask

    task automatic run_random_scans(input int idle, input int stall, input int scans);
        int                got;
        int                pick;
        logic [TIME_W-1:0] step;
        logic [COLS_W-1:0] cols;
        bit                taken;
        idle_pct  = idle;
        stall_pct = stall;
        got       = 0;
        while (got < scans) begin
            pick = $urandom_range(99);
            // mostly on-time scans; some early (throttled), jumps and time going back
            if (pick < 70)
                step = sb.delay_ms + $urandom_range(40);
            else if (pick < 85)
                step = $urandom_range(sb.delay_ms);
            else if (pick < 95)
                step = $urandom;
            else
                step = 32'd0 - $urandom_range(100, 1);
            pick = $urandom_range(9);
            if (pick == 0)
                cols = 8'h00;
            else if (pick == 1)
                cols = 8'hFF;
            else
                cols = COLS_W'($urandom);
            send_scan(clock_ms + step, cols, taken);
            if (taken) begin
                got++;
                if (got == scans / 2)
                    wait_quiet();
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        clock_ms      = '0;
        sb            = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset delay of 10 ms: throttle edges, all rows, row wrap
        send_scan(32'd0, 8'hFF, scan_taken);
        send_scan(32'd9, 8'hFF, scan_taken);
        send_scan(32'd10, 8'hFF, scan_taken);
        send_scan(32'd20, 8'h00, scan_taken);
        send_scan(32'd30, 8'hAA, scan_taken);
        send_scan(32'd40, 8'h55, scan_taken);
        send_scan(32'd50, 8'h0F, scan_taken);
        send_scan(32'd60, 8'hF0, scan_taken);
        send_scan(32'd70, 8'h81, scan_taken);
        send_scan(32'd80, 8'h7E, scan_taken);
        send_scan(32'd90, 8'h00, scan_taken);
        // timestamp wrapping through zero
        send_scan(32'hFFFF_FFFB, 8'h3C, scan_taken);
        send_scan(32'h0000_0002, 8'hFF, scan_taken);
        send_scan(32'h0000_0005, 8'hC3, scan_taken);

        // zero delay: same time and time going back both pass
        write_delay(16'd0);
        send_scan(32'd5, 8'h5A, scan_taken);
        send_scan(32'd4, 8'hA5, scan_taken);

        // largest delay
        write_delay(16'hFFFF);
        send_scan(32'd4 + 32'd65534, 8'hFF, scan_taken);
        send_scan(32'd4 + 32'd65535, 8'h18, scan_taken);
        send_scan(32'hFFFF_FFFF, 8'hE7, scan_taken);

        write_delay(DELAY_RESET);
        run_random_scans(0, 0, 40);
        write_delay(16'd0);
        run_random_scans(72, 0, 40);
        write_delay(DELAY_W'($urandom_range(300, 1)));
        run_random_scans(0, 72, 40);
        write_delay(16'hFFFF);
        run_random_scans(26, 26, 40);

        wait_quiet();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d events never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("button_matrix_scanner_core test passed");
        else
            $display("button_matrix_scanner_core test failed");
        $finish;
    end
endmodule
